// ===== src/rel_pkg.sv =====
// Shared types, codes and constants of the relocation applier.
package rel_pkg;

  localparam int unsigned SECTION_SLOTS_DEF = 256;

  // Request kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_RELOC = 1'b1;

  // Relocation type codes
  localparam logic [7:0] TYPE_ADDR32  = 8'd1;
  localparam logic [7:0] TYPE_LO16    = 8'd4;
  localparam logic [7:0] TYPE_HA16    = 8'd6;
  localparam logic [7:0] TYPE_REL24   = 8'd10;
  localparam logic [7:0] TYPE_NOP     = 8'd201;
  localparam logic [7:0] TYPE_SECTION = 8'd202;
  localparam logic [7:0] TYPE_END     = 8'd203;

  // Result status codes
  localparam logic [1:0] ST_PATCH = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Patch kinds
  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_HALF  = 2'd1;
  localparam logic [1:0] KIND_MERGE = 2'd2;

  localparam logic [31:0] BR_FIELD_MASK   = 32'h03FF_FFFC;
  localparam logic [31:0] NO_SECTION_ADDR = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CLS_ADDR32,
    CLS_LO16,
    CLS_HA16,
    CLS_REL24
  } rel_class_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  rel_type;
    logic [7:0]  section_index;
    logic [15:0] offset_step;
    logic [31:0] addend;
    logic [31:0] section_base;
    logic        base_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] patch_address;
    logic [31:0] patch_data;
    logic [1:0]  patch_kind;
  } out_item_t;

  // Decoded item waiting on the table read
  typedef struct packed {
    logic [1:0]  status;
    rel_class_e  cls;
    logic [31:0] offset;
    logic [31:0] addend;
    logic        mode;
    logic        cur_ok;
    logic        tgt_ok;
  } s1_t;

endpackage

// ===== src/rel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rel_front.sv =====
// Intake stage: decode, cursor, valid bits, table writes and read issue.
module rel_front #(
  parameter int unsigned SECTION_SLOTS = rel_pkg::SECTION_SLOTS_DEF,
  localparam int unsigned IdxW = $clog2(SECTION_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rel_pkg::in_item_t in_item_i,
  output logic              s1_valid_o,
  output rel_pkg::s1_t      s1_o,
  input  logic              s1_ready_i,
  output logic              ram_we_o,
  output logic [IdxW-1:0]   ram_waddr_o,
  output logic [31:0]       ram_wdata_o,
  output logic              ram_re_o,
  output logic [IdxW-1:0]   cur_raddr_o,
  output logic [IdxW-1:0]   tgt_raddr_o
);
  import rel_pkg::*;

  localparam logic [8:0] SlotLimit = 9'(SECTION_SLOTS);

  logic                     mode_q;
  logic [7:0]               cur_sec_q, cur_sec_d;
  logic [31:0]              cur_off_q, cur_off_d;
  logic [SECTION_SLOTS-1:0] valid_q, valid_d;
  logic                     s1_valid_q, s1_valid_d;
  s1_t                      s1_q, s1_d;
  logic                     acc, emit, sec_ok, cur_in;
  logic [IdxW-1:0]          sec_idx, cur_idx;
  logic [31:0]              off_sum;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign sec_ok     = {1'b0, in_item_i.section_index} < SlotLimit;
  assign cur_in     = {1'b0, cur_sec_q} < SlotLimit;
  assign sec_idx    = in_item_i.section_index[IdxW-1:0];
  assign cur_idx    = cur_sec_q[IdxW-1:0];
  assign off_sum    = cur_off_q + {16'b0, in_item_i.offset_step};

  always_comb begin
    cur_sec_d     = cur_sec_q;
    cur_off_d     = cur_off_q;
    valid_d       = valid_q;
    emit          = 1'b0;
    s1_d.status   = ST_PATCH;
    s1_d.cls      = CLS_ADDR32;
    s1_d.offset   = off_sum;
    s1_d.addend   = in_item_i.addend;
    s1_d.mode     = mode_q;
    s1_d.cur_ok   = cur_in && valid_q[cur_idx];
    s1_d.tgt_ok   = sec_ok && valid_q[sec_idx];
    if (acc) begin
      if (in_item_i.op == OP_LOAD) begin
        if (sec_ok) begin
          valid_d[sec_idx] = in_item_i.base_present;
        end
      end else begin
        case (in_item_i.rel_type)
          TYPE_SECTION: begin
            cur_sec_d = in_item_i.section_index;
            cur_off_d = '0;
          end
          TYPE_NOP: begin
            cur_off_d = off_sum;
          end
          TYPE_ADDR32: begin
            cur_off_d = off_sum;
            emit      = 1'b1;
            s1_d.cls  = CLS_ADDR32;
          end
          TYPE_LO16: begin
            cur_off_d = off_sum;
            emit      = 1'b1;
            s1_d.cls  = CLS_LO16;
          end
          TYPE_HA16: begin
            cur_off_d = off_sum;
            emit      = 1'b1;
            s1_d.cls  = CLS_HA16;
          end
          TYPE_REL24: begin
            cur_off_d = off_sum;
            emit      = 1'b1;
            s1_d.cls  = CLS_REL24;
          end
          TYPE_END: begin
            cur_sec_d   = '0;
            cur_off_d   = '0;
            emit        = 1'b1;
            s1_d.status = ST_END;
          end
          default: begin
            cur_sec_d   = '0;
            cur_off_d   = '0;
            emit        = 1'b1;
            s1_d.status = ST_BAD;
          end
        endcase
      end
    end
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      cur_sec_q  <= '0;
      cur_off_q  <= '0;
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cur_sec_q  <= cur_sec_d;
      cur_off_q  <= cur_off_d;
      valid_q    <= valid_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_q <= s1_d;
    end
  end

  // Reads are issued on every accepted item; the result is used only when
  // the item moved into the decode register.
  assign ram_we_o    = acc && (in_item_i.op == OP_LOAD) && sec_ok;
  assign ram_waddr_o = sec_idx;
  assign ram_wdata_o = in_item_i.section_base;
  assign ram_re_o    = acc;
  assign cur_raddr_o = cur_idx;
  assign tgt_raddr_o = sec_idx;
  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;

endmodule

// ===== src/rel_patch.sv =====
// Address/value sums and patch shaping, ending in the output register.
module rel_patch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  rel_pkg::s1_t       s1_i,
  output logic               s1_ready_o,
  input  logic [31:0]        cur_base_i,
  input  logic [31:0]        tgt_base_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rel_pkg::out_item_t out_item_o
);
  import rel_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    rel_class_e  cls;
    logic [31:0] where;
    logic [31:0] value;
  } s2_t;

  logic        s2_valid_q, out_valid_q;
  s2_t         s2_q, s2_d;
  out_item_t   out_q, out_d;
  logic        out_free, s2_free;
  logic [31:0] rel_val;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_ready_o = s2_free;

  always_comb begin
    rel_val     = s1_i.tgt_ok ? (tgt_base_i + s1_i.addend) : NO_SECTION_ADDR;
    s2_d.status = s1_i.status;
    s2_d.cls    = s1_i.cls;
    s2_d.where  = s1_i.cur_ok ? (cur_base_i + s1_i.offset) : NO_SECTION_ADDR;
    s2_d.value  = s1_i.mode ? rel_val : s1_i.addend;
  end

  always_comb begin
    out_d.status        = s2_q.status;
    out_d.patch_address = s2_q.where;
    case (s2_q.cls)
      CLS_ADDR32: begin
        out_d.patch_data = s2_q.value;
        out_d.patch_kind = KIND_WORD;
      end
      CLS_LO16: begin
        out_d.patch_data = {16'b0, s2_q.value[15:0]};
        out_d.patch_kind = KIND_HALF;
      end
      CLS_HA16: begin
        // high half, rounded up when the low half reads as negative
        out_d.patch_data = {16'b0, s2_q.value[31:16] + 16'(s2_q.value[15])};
        out_d.patch_kind = KIND_HALF;
      end
      CLS_REL24: begin
        out_d.patch_data = (s2_q.value - s2_q.where) & BR_FIELD_MASK;
        out_d.patch_kind = KIND_MERGE;
      end
      default: begin
        out_d.patch_data = '0;
        out_d.patch_kind = KIND_WORD;
      end
    endcase
    if (s2_q.status != ST_PATCH) begin
      out_d.patch_address = '0;
      out_d.patch_data    = '0;
      out_d.patch_kind    = KIND_WORD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_i) begin
      s2_q <= s2_d;
    end
    if (out_free && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/rel_relocation_applier.sv =====
// Top level of the relocation applier: intake, base table RAMs, patch pipeline.
//
//   channel   direction  handshake             payload
//   in        in         in_valid_i/in_ready_o in_item_i   (rel_pkg::in_item_t)
//   out       out        out_valid_o/out_ready_i out_item_o (rel_pkg::out_item_t)
//   cfg       in         cfg_we_i              cfg_wdata_i (target_mode)
//
// One item per cycle sustained while the output is not blocked. A result item
// reaches out_valid_o through decode and table read, then the address and value
// adds, then shaping into the output register.
// Reset clears the cursor, target_mode and all section valid bits at once; the
// base table itself is never cleared and needs no sweep.
// in_ready_o drops only while every stage ahead is full and the output is blocked.
module rel_relocation_applier #(
  parameter int unsigned SECTION_SLOTS = rel_pkg::SECTION_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rel_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rel_pkg::out_item_t out_item_o
);
  import rel_pkg::*;

  localparam int unsigned IdxW = $clog2(SECTION_SLOTS);

  logic            s1_valid, s1_ready;
  s1_t             s1;
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, cur_raddr, tgt_raddr;
  logic [31:0]     ram_wdata, cur_base, tgt_base;

  // Intake: item decode, cursor update and valid bits all settle at accept.
  rel_front #(
    .SECTION_SLOTS(SECTION_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .s1_ready_i  (s1_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .cur_raddr_o (cur_raddr),
    .tgt_raddr_o (tgt_raddr)
  );

  // Two copies of the base table, written together, so the cursor section
  // and the target section are looked up in the same cycle. Writes and reads
  // both happen at the accept edge, one item per edge, so a load is always
  // visible to the very next entry without forwarding.
  rel_ram #(
    .WIDTH (32),
    .DEPTH (SECTION_SLOTS)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_raddr),
    .rdata_o (cur_base)
  );

  rel_ram #(
    .WIDTH (32),
    .DEPTH (SECTION_SLOTS)
  ) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (tgt_raddr),
    .rdata_o (tgt_base)
  );

  // Sums, shaping and the output register.
  rel_patch u_patch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .s1_ready_o  (s1_ready),
    .cur_base_i  (cur_base),
    .tgt_base_i  (tgt_base),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // End and bad-type items carry an all-zero patch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_PATCH) |->
      (out_item_o.patch_address == '0) && (out_item_o.patch_data == '0) &&
      (out_item_o.patch_kind == KIND_WORD))
    else $error("non-patch item carries patch fields");

  // A branch merge never touches bits outside the branch field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.patch_kind == KIND_MERGE) |->
      ((out_item_o.patch_data & ~BR_FIELD_MASK) == '0))
    else $error("merge data outside branch field");

  // Intake never stalls while the decode register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> in_ready_o)
    else $error("intake stalled with empty decode stage");

  // A held decode entry keeps its table read data: no table access meanwhile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !s1_ready |-> !ram_re && !ram_we)
    else $error("table accessed while decode stage stalled");

endmodule

// ===== test/rel_relocation_applier_test.sv =====
// Self-checking testbench of the relocation applier: directed table, random streams, scoreboard.
module rel_relocation_applier_test;
  import rel_pkg::*;

  localparam int unsigned SLOTS         = SECTION_SLOTS_DEF;
  localparam int unsigned GAP_MAX       = 11;
  // Long receiver hold-off: far more than the pipeline depth, so intake backs up.
  localparam int unsigned HOLD_CYCLES   = 300;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Pipeline is three deep; a few spare cycles let a no-result item retire.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 320;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned REPORT_MAX    = 10;
  // target_mode per random phase, bit 0 is the first phase.
  localparam logic [NUM_PHASES-1:0] PHASE_MODES = 6'b011010;
  // Type codes outside the known set, at both ends of the byte.
  localparam logic [7:0] UNKNOWN_LOW  = 8'd0;
  localparam logic [7:0] UNKNOWN_HIGH = 8'd255;

  typedef struct packed {
    in_item_t  item;
    logic      fixed;  // want holds a hand-written result
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  always #2 clk = ~clk;

  rel_relocation_applier #(
    .SECTION_SLOTS(SLOTS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the cursor, the base table and target_mode.
  // ---------------------------------------------------------------------------
  logic        tgt_mode;
  logic [7:0]  cur_section;
  logic [31:0] cur_offset;
  logic [31:0] base_addr [SLOTS];
  logic        base_live [SLOTS];

  out_item_t   expected_patches [$];
  dir_row_t    dir_rows [$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned n_patch, n_end, n_bad;
  int unsigned stall_run;
  bit          send_burst, recv_burst;
  bit          hold_req;

  // Absent or never-loaded sections read as all ones, whatever the offset.
  function automatic logic [31:0] section_address(input logic [7:0] sec,
                                                  input logic [31:0] off);
    if (int'(sec) >= SLOTS || !base_live[sec]) return NO_SECTION_ADDR;
    return base_addr[sec] + off;
  endfunction

  // Advances the predictor by one accepted item; returns 1 with res filled
  // when the item causes a result.
  function automatic logic predict_patch(input in_item_t it, output out_item_t res);
    logic [31:0] where;
    logic [31:0] value;
    res = '0;
    if (it.op == OP_LOAD) begin
      if (int'(it.section_index) < SLOTS) begin
        base_addr[it.section_index] = it.section_base;
        base_live[it.section_index] = it.base_present;
      end
      return 1'b0;
    end
    case (it.rel_type)
      TYPE_SECTION: begin
        cur_section = it.section_index;
        cur_offset  = '0;
        return 1'b0;
      end
      TYPE_NOP: begin
        cur_offset = cur_offset + {16'h0, it.offset_step};
        return 1'b0;
      end
      TYPE_ADDR32, TYPE_LO16, TYPE_HA16, TYPE_REL24: ;
      TYPE_END: begin
        cur_section = '0;
        cur_offset  = '0;
        res.status  = ST_END;
        return 1'b1;
      end
      default: begin
        cur_section = '0;
        cur_offset  = '0;
        res.status  = ST_BAD;
        return 1'b1;
      end
    endcase
    cur_offset = cur_offset + {16'h0, it.offset_step};
    where = section_address(cur_section, cur_offset);
    value = tgt_mode ? section_address(it.section_index, it.addend) : it.addend;
    res.status        = ST_PATCH;
    res.patch_address = where;
    case (it.rel_type)
      TYPE_ADDR32: begin
        res.patch_data = value;
        res.patch_kind = KIND_WORD;
      end
      TYPE_LO16: begin
        res.patch_data = {16'h0, value[15:0]};
        res.patch_kind = KIND_HALF;
      end
      TYPE_HA16: begin
        // high half rounded up when the low half reads as negative
        if (value[15]) value = value + 32'h0001_0000;
        res.patch_data = {16'h0, value[31:16]};
        res.patch_kind = KIND_HALF;
      end
      default: begin
        res.patch_data = (value - where) & BR_FIELD_MASK;
        res.patch_kind = KIND_MERGE;
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(input logic op, input logic [7:0] ty,
                                       input logic [7:0] sec, input logic [15:0] step,
                                       input logic [31:0] addend, input logic [31:0] base,
                                       input logic pres);
    in_item_t it;
    it.op            = op;
    it.rel_type      = ty;
    it.section_index = sec;
    it.offset_step   = step;
    it.addend        = addend;
    it.section_base  = base;
    it.base_present  = pres;
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input logic fx, input out_item_t want);
    dir_row_t r;
    r.item  = it;
    r.fixed = fx;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  // Per-item wait, with occasional runs of back-to-back items.
  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Mostly a handful of slots so loads and lookups meet; sometimes any slot.
  function automatic logic [7:0] pick_section();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7));
  endfunction

  // Random entry: mostly section/patch runs, some loads, NOPs, ENDs and junk types.
  function automatic in_item_t random_entry();
    in_item_t    it;
    int unsigned pick;
    it.op            = OP_RELOC;
    it.rel_type      = 8'($urandom);
    it.section_index = pick_section();
    it.offset_step   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 16) * 4);
    it.addend        = $urandom;
    it.section_base  = $urandom;
    it.base_present  = ($urandom_range(0, 6) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 10) it.op = OP_LOAD;
    else if (pick < 20) it.rel_type = TYPE_SECTION;
    else if (pick < 28) it.rel_type = TYPE_NOP;
    else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: it.rel_type = TYPE_ADDR32;
        1: it.rel_type = TYPE_LO16;
        2: it.rel_type = TYPE_HA16;
        default: it.rel_type = TYPE_REL24;
      endcase
    end else if (pick < 95) it.rel_type = TYPE_END;
    // else: the random byte stays, almost always an unknown type
    return it;
  endfunction

  // Offers one item after its gap; on acceptance the predictor runs and the
  // expectation (hand-written one if fx) is queued. Returns at a falling edge.
  task automatic send_item(input in_item_t it, input logic fx, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    logic        hit;
    gap = draw_gap(send_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    hit = predict_patch(it, res);
    if (hit) expected_patches.push_back(fx ? want : res);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected result, then let no-result items retire.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_patches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    drain();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    tgt_mode = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready stalls, one long hold-off on request, scoreboard.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned wait_n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        wait_n   = HOLD_CYCLES;
      end else begin
        wait_n = draw_gap(recv_burst);
      end
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      case (out_item.status)
        ST_PATCH: n_patch++;
        ST_END:   n_end++;
        default:  n_bad++;
      endcase
      if (expected_patches.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("unexpected result: status %0d addr %h data %h kind %0d",
                   out_item.status, out_item.patch_address, out_item.patch_data,
                   out_item.patch_kind);
        fail_count++;
      end else begin
        out_item_t want;
        want = expected_patches.pop_front();
        if (out_item !== want) begin
          if (fail_count < REPORT_MAX)
            $display("mismatch: status %0d/%0d addr %h/%h data %h/%h kind %0d/%0d (exp/got)",
                     want.status, out_item.status, want.patch_address,
                     out_item.patch_address, want.patch_data, out_item.patch_data,
                     want.patch_kind, out_item.patch_kind);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Hang detector: nothing moving on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_run = 0;
    end else begin
      stall_run = stall_run + 1;
      if (stall_run >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned pass, k, ph;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_ready  = 1'b0;
    fail_count = 0;
    items_sent = 0;
    n_patch    = 0;
    n_end      = 0;
    n_bad      = 0;
    stall_run  = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    hold_req   = 1'b0;
    tgt_mode    = 1'b0;
    cur_section = '0;
    cur_offset  = '0;
    for (k = 0; k < SLOTS; k++) begin
      base_addr[k] = '0;
      base_live[k] = 1'b0;
    end

    // Directed table. Fixed rows are checked against the hand-written result
    // on the first walk; everything else goes through the predictor.
    // Fresh from reset: no section loaded, so the patch address is all ones.
    add_row(mk_item(OP_RELOC, TYPE_ADDR32, 8'd0, 16'h0000, 32'h1234_5678, 32'h0, 1'b0),
            1'b1, '{ST_PATCH, NO_SECTION_ADDR, 32'h1234_5678, KIND_WORD});
    add_row(mk_item(OP_RELOC, TYPE_END, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
            1'b1, '{ST_END, 32'h0, 32'h0, KIND_WORD});
    add_row(mk_item(OP_RELOC, UNKNOWN_LOW, 8'd0, 16'h0000, 32'h0, 32'h0, 1'b0),
            1'b1, '{ST_BAD, 32'h0, 32'h0, KIND_WORD});
    add_row(mk_item(OP_RELOC, UNKNOWN_HIGH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    1'b1), 1'b1, '{ST_BAD, 32'h0, 32'h0, KIND_WORD});
    // Base loads; the type field of a load is don't-care.
    add_row(mk_item(OP_LOAD, TYPE_ADDR32, 8'd0, 16'h0, 32'h0, 32'h8000_1000, 1'b1), 1'b0, '0);
    add_row(mk_item(OP_LOAD, UNKNOWN_HIGH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFC,
                    1'b1), 1'b0, '0);
    add_row(mk_item(OP_LOAD, TYPE_END, 8'd7, 16'h0, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_LOAD, TYPE_NOP, 8'd1, 16'h0, 32'h0, 32'h0, 1'b1), 1'b0, '0);
    // Patch run in section 0 with wrap-around offsets and HA carry cases.
    add_row(mk_item(OP_RELOC, TYPE_SECTION, 8'd0, 16'h1234, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_NOP, 8'd0, 16'hFFFF, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_ADDR32, 8'd1, 16'h0004, 32'hFFFF_FFFF, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_LO16, 8'hFF, 16'h0002, 32'h1234_8765, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_HA16, 8'd1, 16'h0002, 32'h1234_8765, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_HA16, 8'd7, 16'h0000, 32'hFFFF_8000, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_HA16, 8'd0, 16'h0000, 32'h0000_7FFF, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_REL24, 8'd0, 16'h0004, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_REL24, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 32'h0, 1'b0),
            1'b0, '0);
    // Top slot as cursor section.
    add_row(mk_item(OP_RELOC, TYPE_SECTION, 8'hFF, 16'h0, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_REL24, 8'd1, 16'hFFFF, 32'h8000_0000, 32'h0, 1'b0),
            1'b0, '0);
    // Cursor on a section loaded as absent, then on one never loaded.
    add_row(mk_item(OP_RELOC, TYPE_SECTION, 8'd7, 16'h0, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_ADDR32, 8'd7, 16'h0008, 32'h0000_0100, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_SECTION, 8'd200, 16'h0, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_LO16, 8'd200, 16'h0010, 32'hA5A5_5A5A, 32'h0, 1'b0),
            1'b0, '0);
    add_row(mk_item(OP_RELOC, TYPE_END, 8'd0, 16'h0, 32'h0, 32'h0, 1'b0),
            1'b1, '{ST_END, 32'h0, 32'h0, KIND_WORD});

    // Reset: held low, then released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the table once per target_mode; the hand-written results assume
    // the state right after reset, so they apply on the first walk only.
    for (pass = 0; pass < 2; pass++) begin
      write_mode(pass[0]);
      for (k = 0; k < dir_rows.size(); k++)
        send_item(dir_rows[k].item, dir_rows[k].fixed && (pass == 0), dir_rows[k].want);
    end

    // Random phases, target_mode per phase from PHASE_MODES; the second one also carries
    // the long receiver hold-off while the sender keeps offering items.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(PHASE_MODES[ph]);
      if (ph == 1) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_item(random_entry(), 1'b0, '0);
    end

    drain();
    fail_count = fail_count + expected_patches.size();
    $display("covered %0d items over both target modes, one long output hold-off",
             items_sent);
    $display("results seen: %0d patches, %0d list ends, %0d bad types, %0d failures",
             n_patch, n_end, n_bad, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
